/* rtl/bwrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwrq_pkg: shared types and constants for the byte waiter rendezvous queue
// Command codes, reply codes, controller/datapath interface structs and the
// default sizes of the two rings.
// ----------------------------------------------------------------------------
package bwrq_pkg;

    // Default sizes
    localparam int WAIT_DEPTH_DEF    = 16;
    localparam int BYTE_DEPTH_DEF    = 256;
    localparam int TASK_ID_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // Input command codes
    localparam logic CMD_GETC = 1'b0;
    localparam logic CMD_PUTC = 1'b1;

    // Reply kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;

    // Datapath operation for the current step of an item
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GIVE_BYTE,    // getc served from the byte ring
        OP_REFUSE,       // getc refused, waiter ring full
        OP_PUSH_WAITER,  // getc queued as a waiter
        OP_DELIVER,      // byte handed to the oldest waiter
        OP_ACK,          // empty acknowledgement to the sender
        OP_PUSH_BYTE     // byte buffered
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the input item
        t_op  op;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic byte_empty;
        logic byte_full;
        logic wait_empty;
        logic wait_full;
    } t_dp_status;

endpackage

/* rtl/byte_waiter_rendezvous_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_waiter_rendezvous_queue: matches console bytes with waiting tasks
//
// An item (i_cmd, i_task_id, i_data_byte) is taken when start is high and
// busy is low. A getc (cmd 0) takes the oldest buffered byte, else queues
// the task as a waiter, else is refused. A put (cmd 1) hands the byte to
// the oldest waiter and acknowledges the sender, else buffers the byte,
// else drops it with an acknowledgement.
// Replies come out one per cycle on o_strobe, with o_last on the final
// reply of an item; the receiver cannot stall, so each reply shows for
// exactly one cycle.
// Sequence: an accepted item is held in r_op while the controller is in
// S_EXEC (then S_ACK for a byte handed to a waiter), with busy high; the
// first reply is registered from r_op in the reply register, and the next
// item can be taken once busy falls.
// Reset clears the heads and counts synchronously and holds busy high
// while it is asserted; ring contents are not cleared and need no clearing
// pass, so items are taken right after reset.
// ----------------------------------------------------------------------------
module byte_waiter_rendezvous_queue #(
    parameter int WAIT_DEPTH    = bwrq_pkg::WAIT_DEPTH_DEF,
    parameter int BYTE_DEPTH    = bwrq_pkg::BYTE_DEPTH_DEF,
    parameter int TASK_ID_WIDTH = bwrq_pkg::TASK_ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [TASK_ID_WIDTH-1:0]      i_task_id,
    input  logic [bwrq_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_strobe,
    output logic [TASK_ID_WIDTH-1:0]      o_dest_task,
    output logic [bwrq_pkg::KIND_W-1:0]   o_reply_kind,
    output logic [bwrq_pkg::BYTE_W-1:0]   o_reply_byte,
    output logic                          o_last
);

    bwrq_pkg::t_ctl_cmd   ctl;
    bwrq_pkg::t_dp_status status;

    // Controller
    bwrq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (status),
        .o_ctl    (ctl),
        .busy     (busy)
    );

    // Datapath
    bwrq_datapath #(
        .WAIT_DEPTH    (WAIT_DEPTH),
        .BYTE_DEPTH    (BYTE_DEPTH),
        .TASK_ID_WIDTH (TASK_ID_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_task_id    (i_task_id),
        .i_data_byte  (i_data_byte),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_dest_task  (o_dest_task),
        .o_reply_kind (o_reply_kind),
        .o_reply_byte (o_reply_byte),
        .o_last       (o_last)
    );

endmodule

/* rtl/bwrq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwrq_ctrl: sequencing controller
// Picks the operation for an item at accept time from the command and the
// ring fill status, then steps the datapath through it.
// ----------------------------------------------------------------------------
module bwrq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_cmd,
    input  bwrq_pkg::t_dp_status  i_status,
    output bwrq_pkg::t_ctl_cmd    o_ctl,
    output logic                  busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ACK
    } t_state;

    t_state        r_state;
    bwrq_pkg::t_op r_op;
    logic          accept;
    bwrq_pkg::t_op n_op;

    // Busy while an item is in flight and while reset is held
    assign busy   = (r_state != S_IDLE) || !i_rst_n;
    assign accept = start && !busy;

    // Decide the item's operation from command and fill levels
    always_comb begin
        if (i_cmd == bwrq_pkg::CMD_GETC) begin
            if (!i_status.byte_empty) begin
                n_op = bwrq_pkg::OP_GIVE_BYTE;
            end else if (i_status.wait_full) begin
                n_op = bwrq_pkg::OP_REFUSE;
            end else begin
                n_op = bwrq_pkg::OP_PUSH_WAITER;
            end
        end else begin
            if (!i_status.wait_empty) begin
                n_op = bwrq_pkg::OP_DELIVER;
            end else if (i_status.byte_full) begin
                n_op = bwrq_pkg::OP_ACK;
            end else begin
                n_op = bwrq_pkg::OP_PUSH_BYTE;
            end
        end
    end

    // State and registered operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= bwrq_pkg::OP_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                        r_op    <= n_op;
                    end
                end
                S_EXEC: begin
                    if (r_op == bwrq_pkg::OP_DELIVER) begin
                        r_state <= S_ACK;
                        r_op    <= bwrq_pkg::OP_ACK;
                    end else begin
                        r_state <= S_IDLE;
                        r_op    <= bwrq_pkg::OP_NONE;
                    end
                end
                S_ACK: begin
                    r_state <= S_IDLE;
                    r_op    <= bwrq_pkg::OP_NONE;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_op    <= bwrq_pkg::OP_NONE;
                end
            endcase
        end
    end

    assign o_ctl.capture = accept;
    assign o_ctl.op      = r_op;

endmodule

/* rtl/bwrq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwrq_datapath: rings, pointers and reply register
// Holds the waiter ring and the byte ring with their head/count pointers,
// the captured item and the registered reply outputs.
// ----------------------------------------------------------------------------
module bwrq_datapath #(
    parameter int WAIT_DEPTH    = bwrq_pkg::WAIT_DEPTH_DEF,
    parameter int BYTE_DEPTH    = bwrq_pkg::BYTE_DEPTH_DEF,
    parameter int TASK_ID_WIDTH = bwrq_pkg::TASK_ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bwrq_pkg::t_ctl_cmd            i_ctl,
    input  logic [TASK_ID_WIDTH-1:0]      i_task_id,
    input  logic [bwrq_pkg::BYTE_W-1:0]   i_data_byte,
    output bwrq_pkg::t_dp_status          o_status,
    output logic                          o_strobe,
    output logic [TASK_ID_WIDTH-1:0]      o_dest_task,
    output logic [bwrq_pkg::KIND_W-1:0]   o_reply_kind,
    output logic [bwrq_pkg::BYTE_W-1:0]   o_reply_byte,
    output logic                          o_last
);

    localparam int WA  = $clog2(WAIT_DEPTH);
    localparam int WC  = $clog2(WAIT_DEPTH + 1);
    localparam int BA  = $clog2(BYTE_DEPTH);
    localparam int BC  = $clog2(BYTE_DEPTH + 1);
    localparam int BW  = bwrq_pkg::BYTE_W;
    localparam int KW  = bwrq_pkg::KIND_W;

    // Ring storage
    logic [TASK_ID_WIDTH-1:0] wait_mem [WAIT_DEPTH];
    logic [BW-1:0]            byte_mem [BYTE_DEPTH];

    // Pointers and captured item
    logic [WA-1:0]            r_wait_head;
    logic [WC-1:0]            r_wait_count;
    logic [BA-1:0]            r_byte_head;
    logic [BC-1:0]            r_byte_count;
    logic [TASK_ID_WIDTH-1:0] r_tid;
    logic [BW-1:0]            r_byte;
    logic [TASK_ID_WIDTH-1:0] r_wait_rd;
    logic [BW-1:0]            r_byte_rd;

    logic [WA:0]              wait_sum;
    logic [WA-1:0]            wait_wr_addr;
    logic [BA:0]              byte_sum;
    logic [BA-1:0]            byte_wr_addr;
    logic [WA-1:0]            wait_head_inc;
    logic [BA-1:0]            byte_head_inc;

    // Fill status
    assign o_status.byte_empty = (r_byte_count == '0);
    assign o_status.byte_full  = (r_byte_count == BC'(BYTE_DEPTH));
    assign o_status.wait_empty = (r_wait_count == '0);
    assign o_status.wait_full  = (r_wait_count == WC'(WAIT_DEPTH));

    // Tail address = head + count, wrapped once
    always_comb begin
        wait_sum = {1'b0, r_wait_head} + (WA+1)'(r_wait_count);
        if (wait_sum >= (WA+1)'(WAIT_DEPTH)) begin
            wait_sum = wait_sum - (WA+1)'(WAIT_DEPTH);
        end
        wait_wr_addr = wait_sum[WA-1:0];

        byte_sum = {1'b0, r_byte_head} + (BA+1)'(r_byte_count);
        if (byte_sum >= (BA+1)'(BYTE_DEPTH)) begin
            byte_sum = byte_sum - (BA+1)'(BYTE_DEPTH);
        end
        byte_wr_addr = byte_sum[BA-1:0];
    end

    // Head advance with wrap
    assign wait_head_inc = (r_wait_head == WA'(WAIT_DEPTH - 1)) ? '0 : r_wait_head + WA'(1);
    assign byte_head_inc = (r_byte_head == BA'(BYTE_DEPTH - 1)) ? '0 : r_byte_head + BA'(1);

    // Ring memories: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == bwrq_pkg::OP_PUSH_WAITER) begin
            wait_mem[wait_wr_addr] <= r_tid;
        end
        r_wait_rd <= wait_mem[r_wait_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == bwrq_pkg::OP_PUSH_BYTE) begin
            byte_mem[byte_wr_addr] <= r_byte;
        end
        r_byte_rd <= byte_mem[r_byte_head];
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_tid  <= i_task_id;
            r_byte <= i_data_byte;
        end
    end

    // Head and count pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_head  <= '0;
            r_wait_count <= '0;
            r_byte_head  <= '0;
            r_byte_count <= '0;
        end else begin
            case (i_ctl.op)
                bwrq_pkg::OP_GIVE_BYTE: begin
                    r_byte_head  <= byte_head_inc;
                    r_byte_count <= r_byte_count - BC'(1);
                end
                bwrq_pkg::OP_PUSH_WAITER: begin
                    r_wait_count <= r_wait_count + WC'(1);
                end
                bwrq_pkg::OP_DELIVER: begin
                    r_wait_head  <= wait_head_inc;
                    r_wait_count <= r_wait_count - WC'(1);
                end
                bwrq_pkg::OP_PUSH_BYTE: begin
                    r_byte_count <= r_byte_count + BC'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Reply strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (i_ctl.op == bwrq_pkg::OP_GIVE_BYTE) ||
                        (i_ctl.op == bwrq_pkg::OP_REFUSE)    ||
                        (i_ctl.op == bwrq_pkg::OP_DELIVER)   ||
                        (i_ctl.op == bwrq_pkg::OP_ACK);
        end
    end

    // Reply payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            bwrq_pkg::OP_GIVE_BYTE: begin
                o_dest_task  <= r_tid;
                o_reply_kind <= bwrq_pkg::KIND_BYTE;
                o_reply_byte <= r_byte_rd;
                o_last       <= 1'b1;
            end
            bwrq_pkg::OP_REFUSE: begin
                o_dest_task  <= r_tid;
                o_reply_kind <= bwrq_pkg::KIND_REFUSED;
                o_reply_byte <= '0;
                o_last       <= 1'b1;
            end
            bwrq_pkg::OP_DELIVER: begin
                o_dest_task  <= r_wait_rd;
                o_reply_kind <= bwrq_pkg::KIND_BYTE;
                o_reply_byte <= r_byte;
                o_last       <= 1'b0;
            end
            bwrq_pkg::OP_ACK: begin
                o_dest_task  <= r_tid;
                o_reply_kind <= bwrq_pkg::KIND_ACK;
                o_reply_byte <= '0;
                o_last       <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/bwrq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwrq_checker: port-level checks for the rendezvous queue
// Watches the top-level ports for reply sequencing and busy behavior.
// ----------------------------------------------------------------------------
module bwrq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [bwrq_pkg::KIND_W-1:0]   o_reply_kind,
    input logic [bwrq_pkg::BYTE_W-1:0]   o_reply_byte,
    input logic                          o_last
);

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after accept");

    // A non-final reply is followed at once by the final one
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_last)
        else $error("second reply missing");

    // The delivery in a pair goes with a byte
    a_pair_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_reply_kind == bwrq_pkg::KIND_BYTE)
        else $error("non-final reply is not a delivery");

    // Only replies of kind KIND_BYTE carry a byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_reply_kind != bwrq_pkg::KIND_BYTE |-> o_reply_byte == '0)
        else $error("byte on a non-delivery reply");

    // Replies only follow a busy cycle
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("reply without work in progress");

endmodule

bind byte_waiter_rendezvous_queue bwrq_checker u_bwrq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_reply_kind (o_reply_kind),
    .o_reply_byte (o_reply_byte),
    .o_last       (o_last)
);
